// ===== hw/rtl/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants and helpers for the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_MAX_DIGITS  = 32;

    // Quotient bits retired per divider cycle
    localparam int STEP_BITS = 4;

    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;

    // Saturate a written base into the supported range
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    // 0..9 -> '0'..'9', 10..35 -> 'A'..'Z'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_A + {1'b0, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/i2a_div.sv =====
// ----------------------------------------------------------------------------
// i2a_div
// Iterative restoring divider: value by a small base, several bits a cycle.
// ----------------------------------------------------------------------------
module i2a_div #(
    parameter int VALUE_WIDTH = i2a_pkg::DEF_VALUE_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [VALUE_WIDTH-1:0]     dividend,
    input  logic [i2a_pkg::BASE_W-1:0] base,
    output logic                       done,
    output logic [VALUE_WIDTH-1:0]     quotient,
    output logic [i2a_pkg::BASE_W-1:0] remainder
);

    localparam int NSTEPS = (VALUE_WIDTH + i2a_pkg::STEP_BITS - 1) / i2a_pkg::STEP_BITS;
    localparam int PAD_W  = NSTEPS * i2a_pkg::STEP_BITS;
    localparam int CNT_W  = $clog2(NSTEPS + 1);

    logic [PAD_W-1:0]           quo_reg, quo_next;
    logic [i2a_pkg::BASE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [PAD_W-1:0]           step_quo;
    logic [i2a_pkg::BASE_W-1:0] step_rem;

    // Dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        logic [i2a_pkg::BASE_W:0] trial;
        step_quo = quo_reg;
        step_rem = rem_reg;
        for (int i = 0; i < i2a_pkg::STEP_BITS; i++) begin
            trial    = {step_rem, step_quo[PAD_W-1]};
            step_quo = {step_quo[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, base}) begin
                step_rem    = i2a_pkg::BASE_W'(trial - {1'b0, base});
                step_quo[0] = 1'b1;
            end else begin
                step_rem = i2a_pkg::BASE_W'(trial);
            end
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = PAD_W'(dividend);
            rem_next  = '0;
            cnt_next  = CNT_W'(NSTEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = step_quo;
            rem_next = step_rem;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/i2a_store.sv =====
// ----------------------------------------------------------------------------
// i2a_store
// Digit memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2a_store #(
    parameter int MAX_DIGITS = i2a_pkg::DEF_MAX_DIGITS
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
    input  logic [i2a_pkg::DIGIT_W-1:0] wr_data,
    input  logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
    output logic [i2a_pkg::DIGIT_W-1:0] rd_data
);

    logic [i2a_pkg::DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [i2a_pkg::DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits - unsigned value to ASCII digits, any base 2..36
// One item at a time: the next is accepted only after the last char of the
//   previous one has been taken. A single divider serves every digit.
// Reset: synchronous active-low aresetn; base returns to 10, block idles.
// ----------------------------------------------------------------------------
//
// Operation:
//   An accepted item is loaded into the quotient register. The shared divider
//   then divides it by the base, retiring four quotient bits a cycle. Each
//   remainder is one digit and goes into the digit memory, least significant
//   first. Division repeats on the quotient until it reaches zero or the
//   memory is full. The digits are then read back in reverse order, mapped to
//   ASCII and presented through an output register, the final one flagged.
//   The block takes no new item until the last char has been taken.
//
//   The base register saturates on write: 0 and 1 act as 2, above 36 as 36.
//   Write it only while idle; the divider reads it directly.
//
module integer_to_ascii_digits #(
    parameter int VALUE_WIDTH = i2a_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = i2a_pkg::DEF_MAX_DIGITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [VALUE_WIDTH-1:0]     s_value_in,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [i2a_pkg::CHAR_W-1:0] m_digit_char,
    output logic                       m_last_digit,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [i2a_pkg::BASE_W-1:0] cfg_number_base
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
    localparam logic [2:0] S_START = 3'd1;  // launch one division
    localparam logic [2:0] S_WAIT  = 3'd2;  // wait for divider, store digit
    localparam logic [2:0] S_READ  = 3'd3;  // address the digit memory
    localparam logic [2:0] S_LOAD  = 3'd4;  // load the output register
    localparam logic [2:0] S_OUT   = 3'd5;  // hold the char until taken

    logic [2:0]                   state_reg, state_next;
    logic [i2a_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [VALUE_WIDTH-1:0]       quo_reg, quo_next;      // remaining quotient
    logic [IDX_W-1:0]             wr_idx_reg, wr_idx_next; // digits stored so far
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next; // next digit to emit
    logic                         m_valid_reg, m_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                         last_reg, last_next;

    logic                         div_start;
    logic                         div_done;
    logic [VALUE_WIDTH-1:0]       div_quo;
    logic [i2a_pkg::BASE_W-1:0]   div_rem;
    logic                         st_wr_en;
    logic [i2a_pkg::DIGIT_W-1:0]  st_rd_data;

    // Shared divider: one division per digit
    i2a_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (quo_reg),
        .base      (base_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Digit memory, written least significant first, read back reversed
    i2a_store #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (div_rem),
        .rd_addr (rd_idx_reg),
        .rd_data (st_rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == S_START);
    assign st_wr_en  = (state_reg == S_WAIT) && div_done;

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        quo_next     = quo_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        // Saturate the base on write
        if (cfg_valid && cfg_ready) begin
            base_next = i2a_pkg::clamp_base(cfg_number_base);
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    quo_next    = s_value_in;
                    wr_idx_next = '0;
                    state_next  = S_START;
                end
            end
            S_START: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    quo_next = div_quo;
                    // Stop on a zero quotient or a full memory; emit from the top
                    if (div_quo == '0 || wr_idx_reg == IDX_W'(MAX_DIGITS - 1)) begin
                        rd_idx_next = wr_idx_reg;
                        quo_next    = '0;
                        state_next  = S_READ;
                    end else begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                        state_next  = S_START;
                    end
                end
            end
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                char_next    = i2a_pkg::digit_to_ascii(st_rd_data);
                last_next    = (rd_idx_reg == '0);
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            base_reg    <= i2a_pkg::BASE_RESET;
            quo_reg     <= '0;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            quo_reg     <= quo_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

`ifndef SYNTH
    // A char is only shown while the sequencer holds it
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == S_OUT)
        else $error("m_valid outside output state");

    // No new item while a char is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg)
        else $error("input ready while output pending");

    // Taking the flagged char frees the block
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_digit) |=> s_ready)
        else $error("block not idle after last char");

    // Base always within the supported range
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg >= i2a_pkg::BASE_MIN && base_reg <= i2a_pkg::BASE_MAX)
        else $error("base out of range");
`endif

endmodule
